FILE: hdl/assert_macros.svh
// Assertion macros used by the top level of the divider word calculator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Signal property checked at every clock edge outside reset.
`define FSWC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked at every clock edge outside reset.
`define FSWC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fswc_pkg.sv
// Types and constants of the fractional-N divider word calculator.
package fswc_pkg;

  localparam int FREQ_W    = 30;
  localparam int REF_W     = 26;
  localparam int DEN_W     = 27;
  localparam int NUM_W     = 33;
  localparam int REM_W     = 27;
  localparam int INT_QBITS = 9;
  localparam int BAND_W    = 4;
  localparam int DIV_W     = 5;
  localparam int INT_W     = 7;
  localparam int FRAC_W    = 20;

  localparam logic [FREQ_W-1:0] FREQ_MIN = 30'd142000000;
  localparam logic [FREQ_W-1:0] FREQ_MAX = 30'd1050000000;
  localparam logic [FREQ_W-1:0] TH_DIV4  = 30'd705000000;
  localparam logic [FREQ_W-1:0] TH_DIV6  = 30'd525000000;
  localparam logic [FREQ_W-1:0] TH_DIV8  = 30'd353000000;
  localparam logic [FREQ_W-1:0] TH_DIV12 = 30'd239000000;
  localparam logic [FREQ_W-1:0] TH_DIV16 = 30'd177000000;

  localparam logic [REF_W-1:0] REF_MIN   = 26'd10000000;
  localparam logic [REF_W-1:0] REF_MAX   = 26'd40000000;
  localparam logic [DEN_W-1:0] DEN_RESET = 27'd60000000;
  localparam logic [DEN_W-1:0] DEN_MIN   = 27'd20000000;
  localparam logic [DEN_W-1:0] DEN_MAX   = 27'd80000000;

  localparam logic [DIV_W-1:0] DIV_4  = 5'd4;
  localparam logic [DIV_W-1:0] DIV_6  = 5'd6;
  localparam logic [DIV_W-1:0] DIV_8  = 5'd8;
  localparam logic [DIV_W-1:0] DIV_12 = 5'd12;
  localparam logic [DIV_W-1:0] DIV_16 = 5'd16;
  localparam logic [DIV_W-1:0] DIV_24 = 5'd24;

  localparam logic [BAND_W-1:0] BAND_C0 = 4'd8;
  localparam logic [BAND_W-1:0] BAND_C1 = 4'd9;
  localparam logic [BAND_W-1:0] BAND_C2 = 4'd10;
  localparam logic [BAND_W-1:0] BAND_C3 = 4'd11;
  localparam logic [BAND_W-1:0] BAND_C4 = 4'd12;
  localparam logic [BAND_W-1:0] BAND_C5 = 4'd13;

  localparam logic [INT_QBITS-1:0] Q_SAT   = 9'd128;
  localparam logic [INT_W-1:0]     INT_SAT = 7'd127;
  localparam logic [FRAC_W-1:0]    FRAC_SAT = 20'hFFFFF;

  typedef struct packed {
    logic [BAND_W-1:0] band_code;
    logic [DIV_W-1:0]  out_divider;
  } tag_t;

endpackage

FILE: hdl/fswc_front.sv
// Front stage: clamp, divider and band pick, numerator product.
module fswc_front #(
  parameter int QW = 28
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [fswc_pkg::FREQ_W-1:0] freq_i,
  output logic                        valid_o,
  output fswc_pkg::tag_t              tag_o,
  output logic [fswc_pkg::REM_W-1:0]  rem_o,
  output logic [QW-1:0]               lo_o
);

  localparam int PROD_W = fswc_pkg::FREQ_W + fswc_pkg::DIV_W;
  localparam int LO_NUM = fswc_pkg::INT_QBITS;

  logic [fswc_pkg::FREQ_W-1:0] freq_c;
  fswc_pkg::tag_t              tag_c;
  logic [PROD_W-1:0]           prod;
  logic [fswc_pkg::NUM_W-1:0]  num;
  logic                        valid_q;
  fswc_pkg::tag_t              tag_q;
  logic [fswc_pkg::REM_W-1:0]  rem_q;
  logic [QW-1:0]               lo_q;

  always_comb begin
    if (freq_i < fswc_pkg::FREQ_MIN) begin
      freq_c = fswc_pkg::FREQ_MIN;
    end else if (freq_i > fswc_pkg::FREQ_MAX) begin
      freq_c = fswc_pkg::FREQ_MAX;
    end else begin
      freq_c = freq_i;
    end
    if (freq_c >= fswc_pkg::TH_DIV4) begin
      tag_c = '{band_code: fswc_pkg::BAND_C0, out_divider: fswc_pkg::DIV_4};
    end else if (freq_c >= fswc_pkg::TH_DIV6) begin
      tag_c = '{band_code: fswc_pkg::BAND_C1, out_divider: fswc_pkg::DIV_6};
    end else if (freq_c >= fswc_pkg::TH_DIV8) begin
      tag_c = '{band_code: fswc_pkg::BAND_C2, out_divider: fswc_pkg::DIV_8};
    end else if (freq_c >= fswc_pkg::TH_DIV12) begin
      tag_c = '{band_code: fswc_pkg::BAND_C3, out_divider: fswc_pkg::DIV_12};
    end else if (freq_c >= fswc_pkg::TH_DIV16) begin
      tag_c = '{band_code: fswc_pkg::BAND_C4, out_divider: fswc_pkg::DIV_16};
    end else begin
      tag_c = '{band_code: fswc_pkg::BAND_C5, out_divider: fswc_pkg::DIV_24};
    end
  end

  assign prod = {{fswc_pkg::DIV_W{1'b0}}, freq_c} *
                {{fswc_pkg::FREQ_W{1'b0}}, tag_c.out_divider};
  assign num  = prod[fswc_pkg::NUM_W-1:0];

  // Upper numerator bits stay below the divisor, so they seed the remainder.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q <= tag_c;
      rem_q <= fswc_pkg::REM_W'(num[fswc_pkg::NUM_W-1:LO_NUM]);
      lo_q  <= {num[LO_NUM-1:0], {(QW-LO_NUM){1'b0}}};
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign rem_o   = rem_q;
  assign lo_o    = lo_q;

endmodule

FILE: hdl/fswc_div_cell.sv
// One restoring-division cell: yields one quotient bit per beat.
module fswc_div_cell #(
  parameter int QW = 28
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic [fswc_pkg::DEN_W-1:0] den_i,
  input  logic                       valid_i,
  input  fswc_pkg::tag_t             tag_i,
  input  logic [fswc_pkg::REM_W-1:0] rem_i,
  input  logic [QW-1:0]              lo_i,
  output logic                       valid_o,
  output fswc_pkg::tag_t             tag_o,
  output logic [fswc_pkg::REM_W-1:0] rem_o,
  output logic [QW-1:0]              lo_o
);

  logic [fswc_pkg::REM_W:0]   trial;
  logic [fswc_pkg::REM_W:0]   diff;
  logic                       ge;
  logic                       valid_q;
  fswc_pkg::tag_t             tag_q;
  logic [fswc_pkg::REM_W-1:0] rem_q;
  logic [QW-1:0]              lo_q;

  assign trial = {rem_i, lo_i[QW-1]};
  assign diff  = trial - {1'b0, den_i};
  assign ge    = (trial >= {1'b0, den_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q <= tag_i;
      rem_q <= ge ? diff[fswc_pkg::REM_W-1:0] : trial[fswc_pkg::REM_W-1:0];
      lo_q  <= {lo_i[QW-2:0], ge};
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign rem_o   = rem_q;
  assign lo_o    = lo_q;

endmodule

FILE: hdl/fracn_synth_word_calc.sv
// Top level of the fractional-N divider word calculator.
// Throughput: one beat per cycle while no output beat is stalled; one front stage,
// FRAC_BITS + 9 division cells of one quotient bit each, then the output register.
// The whole pipeline halts while an output beat waits unaccepted.
// Reset clears all valid flags and loads a 30 MHz reference.
`include "assert_macros.svh"

module fracn_synth_word_calc #(
  parameter int FRAC_BITS = 19
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [25:0] cfg_data_i,    // ref_clock_hz
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [29:0] freq_hz
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // band_code, out_divider, pll_int, pll_frac
);

  localparam int QW = fswc_pkg::INT_QBITS + FRAC_BITS;

  logic [fswc_pkg::DEN_W-1:0]  den_q;
  logic [fswc_pkg::REF_W-1:0]  ref_c;
  logic                        en;

  logic                        valid_s [0:QW];
  fswc_pkg::tag_t              tag_s   [0:QW];
  logic [fswc_pkg::REM_W-1:0]  rem_s   [0:QW];
  logic [QW-1:0]               lo_s    [0:QW];

  logic [fswc_pkg::INT_QBITS-1:0] q;
  logic [FRAC_BITS-1:0]           f;
  logic [FRAC_BITS+fswc_pkg::FRAC_W:0] fwide;
  logic [fswc_pkg::FRAC_W-1:0]    frac_c;
  logic [fswc_pkg::INT_W-1:0]     int_c;
  logic [fswc_pkg::INT_QBITS-1:0] qm1;

  logic                        out_valid_q;
  fswc_pkg::tag_t              out_tag_q;
  logic [fswc_pkg::INT_W-1:0]  out_int_q;
  logic [fswc_pkg::FRAC_W-1:0] out_frac_q;

  // Reference register, kept as clamped divisor 2 * ref.
  always_comb begin
    if (cfg_data_i < fswc_pkg::REF_MIN) begin
      ref_c = fswc_pkg::REF_MIN;
    end else if (cfg_data_i > fswc_pkg::REF_MAX) begin
      ref_c = fswc_pkg::REF_MAX;
    end else begin
      ref_c = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      den_q <= fswc_pkg::DEN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      den_q <= {ref_c, 1'b0};
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  fswc_front #(.QW(QW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .freq_i  (s_axis_tdata[fswc_pkg::FREQ_W-1:0]),
    .valid_o (valid_s[0]),
    .tag_o   (tag_s[0]),
    .rem_o   (rem_s[0]),
    .lo_o    (lo_s[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    fswc_div_cell #(.QW(QW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .den_i   (den_q),
      .valid_i (valid_s[i]),
      .tag_i   (tag_s[i]),
      .rem_i   (rem_s[i]),
      .lo_i    (lo_s[i]),
      .valid_o (valid_s[i+1]),
      .tag_o   (tag_s[i+1]),
      .rem_o   (rem_s[i+1]),
      .lo_o    (lo_s[i+1])
    );
  end

  // Quotient split into integer and fraction words, with saturation.
  assign q     = lo_s[QW][QW-1 -: fswc_pkg::INT_QBITS];
  assign qm1   = q - fswc_pkg::INT_QBITS'(1);
  assign f     = lo_s[QW][FRAC_BITS-1:0];

  always_comb begin
    fwide  = {{fswc_pkg::FRAC_W{1'b0}}, 1'b1, f};
    int_c  = qm1[fswc_pkg::INT_W-1:0];
    frac_c = fwide[fswc_pkg::FRAC_W-1:0];
    if (q == '0) begin
      fwide  = {{fswc_pkg::FRAC_W{1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
      int_c  = '0;
      frac_c = fwide[fswc_pkg::FRAC_W-1:0];
    end else if (q > fswc_pkg::Q_SAT) begin
      int_c  = fswc_pkg::INT_SAT;
      frac_c = fswc_pkg::FRAC_SAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_s[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_tag_q  <= tag_s[QW];
      out_int_q  <= int_c;
      out_frac_q <= frac_c;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_frac_q, out_int_q,
                          out_tag_q.out_divider, out_tag_q.band_code};

  `FSWC_ASSERT(a_den_range,
    (den_q >= fswc_pkg::DEN_MIN) && (den_q <= fswc_pkg::DEN_MAX),
    "divisor left its clamped range")
  `FSWC_ASSERT(a_ready_follows_out, s_axis_tready == (!m_axis_tvalid || m_axis_tready),
    "input ready does not track output slot")
  `FSWC_ASSERT_IMP(a_band_code, m_axis_tvalid,
    (m_axis_tdata[3:0] >= fswc_pkg::BAND_C0) && (m_axis_tdata[3:0] <= fswc_pkg::BAND_C5),
    "band code out of range")
  `FSWC_ASSERT_IMP(a_divider, m_axis_tvalid,
    (out_tag_q.out_divider == fswc_pkg::DIV_4) || (out_tag_q.out_divider == fswc_pkg::DIV_6) ||
    (out_tag_q.out_divider == fswc_pkg::DIV_8) || (out_tag_q.out_divider == fswc_pkg::DIV_12) ||
    (out_tag_q.out_divider == fswc_pkg::DIV_16) || (out_tag_q.out_divider == fswc_pkg::DIV_24),
    "illegal output divider")

endmodule
